// ===== hdl/bwt_pkg.sv =====
// Shared types and constants of the barycentric weight pipeline.
`default_nettype none
package bwt_pkg;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned MAG_W   = PROD_W;
  localparam int unsigned QB      = 33;
  localparam int unsigned W_W     = 32;

  typedef struct packed {
    logic neg_a;
    logic neg_b;
    logic degen;
  } bwt_sign_t;

  typedef struct packed {
    bwt_sign_t sign;
    logic      ovf_a;
    logic      ovf_b;
  } bwt_flag_t;

  function automatic logic [W_W-1:0] bwt_sat(input logic neg, input logic ovf,
                                              input logic [QB-1:0] q);
    logic [QB-1:0] nq;
    nq = QB'(0) - q;
    if (neg) begin
      if (ovf || q[QB-1] || (q[QB-2] && (|q[QB-3:0]))) begin
        return {1'b1, {(W_W-1){1'b0}}};
      end
      return nq[W_W-1:0];
    end
    if (ovf || q[QB-1] || q[QB-2]) begin
      return {1'b0, {(W_W-1){1'b1}}};
    end
    return q[W_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/bwt_front.sv =====
// Edge differences, cross products and magnitudes: four register stages.
`default_nettype none
module bwt_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                en_i,
  input  wire                                valid_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] a_x_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] a_y_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] b_x_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] b_y_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] c_x_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] c_y_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] p_x_i,
  input  wire logic signed [bwt_pkg::COORD_W-1:0] p_y_i,
  output logic                               valid_o,
  output logic [bwt_pkg::MAG_W-1:0]          na_mag_o,
  output logic [bwt_pkg::MAG_W-1:0]          nb_mag_o,
  output logic [bwt_pkg::MAG_W-1:0]          area_mag_o,
  output bwt_pkg::bwt_sign_t                 sign_o
);
  import bwt_pkg::*;

  logic [3:0] v_q;
  logic signed [DIFF_W-1:0] abx_q, aby_q, acx_q, acy_q, bcx_q, bcy_q;
  logic signed [DIFF_W-1:0] apx_q, apy_q, bpx_q, bpy_q;
  logic signed [PROD_W-1:0] p0_d, p1_d, p2_d, p3_d, p4_d, p5_d;
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [SUM_W-1:0]  area_q, na_q, nb_q;
  logic [MAG_W-1:0]         na_mag_q, nb_mag_q, area_mag_q;
  bwt_sign_t                sign_q;

  always_comb begin
    p0_d = abx_q * acy_q;
    p1_d = aby_q * acx_q;
    p2_d = bcx_q * bpy_q;
    p3_d = bpx_q * bcy_q;
    p4_d = apx_q * acy_q;
    p5_d = acx_q * apy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q <= DIFF_W'(b_x_i) - DIFF_W'(a_x_i);
      aby_q <= DIFF_W'(b_y_i) - DIFF_W'(a_y_i);
      acx_q <= DIFF_W'(c_x_i) - DIFF_W'(a_x_i);
      acy_q <= DIFF_W'(c_y_i) - DIFF_W'(a_y_i);
      bcx_q <= DIFF_W'(c_x_i) - DIFF_W'(b_x_i);
      bcy_q <= DIFF_W'(c_y_i) - DIFF_W'(b_y_i);
      apx_q <= DIFF_W'(p_x_i) - DIFF_W'(a_x_i);
      apy_q <= DIFF_W'(p_y_i) - DIFF_W'(a_y_i);
      bpx_q <= DIFF_W'(p_x_i) - DIFF_W'(b_x_i);
      bpy_q <= DIFF_W'(p_y_i) - DIFF_W'(b_y_i);
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
      p5_q <= p5_d;
      area_q <= SUM_W'(p0_q) - SUM_W'(p1_q);
      na_q   <= SUM_W'(p2_q) - SUM_W'(p3_q);
      nb_q   <= SUM_W'(p4_q) - SUM_W'(p5_q);
      area_mag_q   <= MAG_W'(area_q[SUM_W-1] ? -area_q : area_q);
      na_mag_q     <= MAG_W'(na_q[SUM_W-1] ? -na_q : na_q);
      nb_mag_q     <= MAG_W'(nb_q[SUM_W-1] ? -nb_q : nb_q);
      sign_q.neg_a <= na_q[SUM_W-1] ^ area_q[SUM_W-1];
      sign_q.neg_b <= nb_q[SUM_W-1] ^ area_q[SUM_W-1];
      sign_q.degen <= (area_q == '0);
    end
  end

  assign valid_o    = v_q[3];
  assign na_mag_o   = na_mag_q;
  assign nb_mag_o   = nb_mag_q;
  assign area_mag_o = area_mag_q;
  assign sign_o     = sign_q;
endmodule
`default_nettype wire

// ===== hdl/bwt_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, rounded.
`default_nettype none
module bwt_div #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire logic [bwt_pkg::MAG_W-1:0] na_mag_i,
  input  wire logic [bwt_pkg::MAG_W-1:0] nb_mag_i,
  input  wire logic [bwt_pkg::MAG_W-1:0] area_mag_i,
  input  wire bwt_pkg::bwt_sign_t      sign_i,
  output logic                         valid_o,
  output logic [bwt_pkg::QB-1:0]       qa_o,
  output logic [bwt_pkg::QB-1:0]       qb_o,
  output bwt_pkg::bwt_flag_t           flag_o
);
  import bwt_pkg::*;

  localparam int unsigned DW = MAG_W + WEIGHT_FRAC_BITS + 1;

  logic [DW-1:0]    da_d, db_d;
  logic [MAG_W-1:0] ra_q [QB+1];
  logic [MAG_W-1:0] rb_q [QB+1];
  logic [QB-1:0]    la_q [QB+1];
  logic [QB-1:0]    lb_q [QB+1];
  logic [QB-1:0]    qa_q [QB+1];
  logic [QB-1:0]    qb_q [QB+1];
  logic [MAG_W-1:0] ud_q [QB+1];
  bwt_flag_t        fl_q [QB+1];
  logic [QB:0]      v_q;

  always_comb begin
    da_d = {na_mag_i, WEIGHT_FRAC_BITS'(0), 1'b0} >> 1;
    db_d = {nb_mag_i, WEIGHT_FRAC_BITS'(0), 1'b0} >> 1;
    da_d = da_d + DW'(area_mag_i >> 1);
    db_d = db_d + DW'(area_mag_i >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q[0]       <= MAG_W'(da_d[DW-1:QB]);
      rb_q[0]       <= MAG_W'(db_d[DW-1:QB]);
      la_q[0]       <= da_d[QB-1:0];
      lb_q[0]       <= db_d[QB-1:0];
      qa_q[0]       <= '0;
      qb_q[0]       <= '0;
      ud_q[0]       <= area_mag_i;
      fl_q[0].sign  <= sign_i;
      fl_q[0].ovf_a <= (MAG_W'(da_d[DW-1:QB]) >= area_mag_i);
      fl_q[0].ovf_b <= (MAG_W'(db_d[DW-1:QB]) >= area_mag_i);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [MAG_W:0] ta, tb;
    logic           ga, gb;
    always_comb begin
      ta = {ra_q[k], la_q[k][QB-1]};
      tb = {rb_q[k], lb_q[k][QB-1]};
      ga = (ta >= {1'b0, ud_q[k]});
      gb = (tb >= {1'b0, ud_q[k]});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[k+1] <= MAG_W'(ga ? ta - {1'b0, ud_q[k]} : ta);
        rb_q[k+1] <= MAG_W'(gb ? tb - {1'b0, ud_q[k]} : tb);
        la_q[k+1] <= {la_q[k][QB-2:0], 1'b0};
        lb_q[k+1] <= {lb_q[k][QB-2:0], 1'b0};
        qa_q[k+1] <= {qa_q[k][QB-2:0], ga};
        qb_q[k+1] <= {qb_q[k][QB-2:0], gb};
        ud_q[k+1] <= ud_q[k];
        fl_q[k+1] <= fl_q[k];
      end
    end
  end

  assign valid_o = v_q[QB];
  assign qa_o    = qa_q[QB];
  assign qb_o    = qb_q[QB];
  assign flag_o  = fl_q[QB];
endmodule
`default_nettype wire

// ===== hdl/bwt_back.sv =====
// Sign, saturation and gamma, ending in the output register.
`default_nettype none
module bwt_back #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire logic [bwt_pkg::QB-1:0]  qa_i,
  input  wire logic [bwt_pkg::QB-1:0]  qb_i,
  input  wire bwt_pkg::bwt_flag_t      flag_i,
  output logic                         valid_o,
  output logic [bwt_pkg::W_W-1:0]      alpha_o,
  output logic [bwt_pkg::W_W-1:0]      beta_o,
  output logic [bwt_pkg::W_W-1:0]      gamma_o,
  output logic                         degenerate_o
);
  import bwt_pkg::*;

  localparam int unsigned G_W = W_W + 2;

  logic [1:0]              v_q;
  logic signed [W_W-1:0]   al_q, be_q;
  logic                    dg_q;
  logic signed [G_W-1:0]   g_d;
  logic [W_W-1:0]          gs_d;
  logic [W_W-1:0]          alpha_q, beta_q, gamma_q;
  logic                    degen_q;

  always_comb begin
    g_d = (G_W'(1) << WEIGHT_FRAC_BITS) - G_W'(al_q) - G_W'(be_q);
    if (g_d > G_W'(signed'({1'b0, {(W_W-1){1'b1}}}))) begin
      gs_d = {1'b0, {(W_W-1){1'b1}}};
    end else if (g_d < -(G_W'(1) << (W_W-1))) begin
      gs_d = {1'b1, {(W_W-1){1'b0}}};
    end else begin
      gs_d = g_d[W_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      al_q    <= bwt_sat(flag_i.sign.neg_a, flag_i.ovf_a, qa_i);
      be_q    <= bwt_sat(flag_i.sign.neg_b, flag_i.ovf_b, qb_i);
      dg_q    <= flag_i.sign.degen;
      alpha_q <= dg_q ? '0 : al_q;
      beta_q  <= dg_q ? '0 : be_q;
      gamma_q <= dg_q ? '0 : gs_d;
      degen_q <= dg_q;
    end
  end

  assign valid_o      = v_q[1];
  assign alpha_o      = alpha_q;
  assign beta_o       = beta_q;
  assign gamma_o      = gamma_q;
  assign degenerate_o = degen_q;
endmodule
`default_nettype wire

// ===== hdl/barycentric_weights_2d.sv =====
// Top level of the 2D barycentric weight pipeline.
// One transaction is accepted every clock while the output is not stalled; each result
// passes through four front stages (differences, cross products, area and numerators,
// magnitudes), one rounding stage, 33 divider stages producing one quotient bit each
// for alpha and beta side by side, and two stages for saturation and gamma. When the
// output is stalled the whole pipeline holds. A zero area sets tuser and zeroes all
// weights.
`default_nettype none
module barycentric_weights_2d #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, 16 bits each from bit 0
  input  wire [127:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // alpha [31:0], beta [63:32], gamma [95:64]
  output logic [95:0]  m_axis_tdata_o,
  // degenerate
  output logic         m_axis_tuser_o
);
  import bwt_pkg::*;

  logic             en;
  logic             f_valid, d_valid, b_valid;
  logic [MAG_W-1:0] na_mag, nb_mag, area_mag;
  bwt_sign_t        sign;
  logic [QB-1:0]    qa, qb;
  bwt_flag_t        flag;
  logic [W_W-1:0]   alpha, beta, gamma;
  logic             degen;

  assign en = !b_valid || m_axis_tready_i;

  bwt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid_i),
    .a_x_i      (s_axis_tdata_i[15:0]),
    .a_y_i      (s_axis_tdata_i[31:16]),
    .b_x_i      (s_axis_tdata_i[47:32]),
    .b_y_i      (s_axis_tdata_i[63:48]),
    .c_x_i      (s_axis_tdata_i[79:64]),
    .c_y_i      (s_axis_tdata_i[95:80]),
    .p_x_i      (s_axis_tdata_i[111:96]),
    .p_y_i      (s_axis_tdata_i[127:112]),
    .valid_o    (f_valid),
    .na_mag_o   (na_mag),
    .nb_mag_o   (nb_mag),
    .area_mag_o (area_mag),
    .sign_o     (sign)
  );

  bwt_div #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_valid),
    .na_mag_i   (na_mag),
    .nb_mag_i   (nb_mag),
    .area_mag_i (area_mag),
    .sign_i     (sign),
    .valid_o    (d_valid),
    .qa_o       (qa),
    .qb_o       (qb),
    .flag_o     (flag)
  );

  bwt_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (d_valid),
    .qa_i         (qa),
    .qb_i         (qb),
    .flag_i       (flag),
    .valid_o      (b_valid),
    .alpha_o      (alpha),
    .beta_o       (beta),
    .gamma_o      (gamma),
    .degenerate_o (degen)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = b_valid;
  assign m_axis_tdata_o  = {gamma, beta, alpha};
  assign m_axis_tuser_o  = degen;

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate result carries nonzero weights");

  a_stall_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  a_unit_gamma : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o && alpha == '0 && beta == '0
      |-> gamma == W_W'(1) << WEIGHT_FRAC_BITS)
    else $error("gamma is not one when alpha and beta are zero");
endmodule
`default_nettype wire

// ===== bench/bwt_checker.sv =====
// Checker: predicts barycentric weights for each input transaction and compares outputs.
`timescale 1ns / 100ps
module bwt_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire [127:0] s_tdata_i,
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire [95:0]  m_tdata_i,
  input  wire         m_tuser_i,
  output int          errors_o,
  output int          pending_o
);
  localparam int WFB = 16;

  typedef struct packed {
    logic [31:0] alpha;
    logic [31:0] beta;
    logic [31:0] gamma;
    logic        degen;
  } weights_t;

  weights_t weights_q[$];

  function automatic longint sat_w(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    logic   neg;
    longint un;
    longint ud;
    longint q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = ((un <<< WFB) + (ud >>> 1)) / ud;
    return sat_w(neg ? -q : q);
  endfunction

  function automatic weights_t barycentric(input logic [127:0] d);
    longint   c[8];
    longint   area;
    longint   al;
    longint   be;
    longint   ga;
    weights_t w;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
    area = (c[2] - c[0]) * (c[5] - c[1]) - (c[3] - c[1]) * (c[4] - c[0]);
    w = '0;
    if (area == 0) begin
      w.degen = 1'b1;
    end else begin
      al = round_div((c[4] - c[2]) * (c[7] - c[3]) - (c[6] - c[2]) * (c[5] - c[3]), area);
      be = round_div((c[6] - c[0]) * (c[5] - c[1]) - (c[4] - c[0]) * (c[7] - c[1]), area);
      ga = sat_w((64'sd1 <<< WFB) - al - be);
      w.alpha = al[31:0];
      w.beta  = be[31:0];
      w.gamma = ga[31:0];
    end
    return w;
  endfunction

  assign pending_o = weights_q.size();

  always @(posedge clk_i) begin
    weights_t e;
    if (rst_ni && s_tvalid_i && s_tready_i) weights_q.push_back(barycentric(s_tdata_i));
    if (rst_ni && m_tvalid_i && m_tready_i) begin
      if (weights_q.size() == 0) begin
        $error("unexpected result %h user %b", m_tdata_i, m_tuser_i);
        errors_o <= errors_o + 1;
      end else begin
        e = weights_q.pop_front();
        if (m_tdata_i[31:0] !== e.alpha || m_tdata_i[63:32] !== e.beta ||
            m_tdata_i[95:64] !== e.gamma || m_tuser_i !== e.degen) begin
          if (m_tdata_i[31:0] !== e.alpha)
            $error("alpha expected %h actual %h", e.alpha, m_tdata_i[31:0]);
          if (m_tdata_i[63:32] !== e.beta)
            $error("beta expected %h actual %h", e.beta, m_tdata_i[63:32]);
          if (m_tdata_i[95:64] !== e.gamma)
            $error("gamma expected %h actual %h", e.gamma, m_tdata_i[95:64]);
          if (m_tuser_i !== e.degen)
            $error("degenerate expected %b actual %b", e.degen, m_tuser_i);
          errors_o <= errors_o + 1;
        end
      end
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives triangle/point transactions into the weight pipeline.
`timescale 1ns / 100ps
module tb_top;
  localparam int N_RAND = 1450;
  localparam int LIMIT  = 400000;

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic         m_tuser;
  int           errors;
  int           pending;
  int           cycles;
  bit           calm;
  bit           hold_done;

  barycentric_weights_2d dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  bwt_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .m_tuser_i(m_tuser), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [127:0] pack8(input logic [15:0] v[8]);
    logic [127:0] d;
    for (int i = 0; i < 8; i++) d[16*i +: 16] = v[i];
    return d;
  endfunction

  function automatic logic [127:0] random_item();
    logic [15:0] v[8];
    int          k;
    for (int i = 0; i < 8; i++) v[i] = rand_coord();
    k = $urandom_range(0, 9);
    if (k == 0) begin
      v[2] = v[0]; v[3] = v[1];
    end else if (k == 1) begin
      v[4] = v[0] + (v[2] - v[0]) * 16'd2; v[5] = v[1] + (v[3] - v[1]) * 16'd2;
    end else if (k == 2) begin
      v[6] = v[$urandom_range(0, 2) * 2]; v[7] = v[1 + 2 * $urandom_range(0, 2)];
    end else if (k == 3) begin
      v[2] = v[0] + 16'd1; v[3] = v[1]; v[4] = v[0]; v[5] = v[1] + 16'd1;
    end
    return pack8(v);
  endfunction

  task automatic send(input logic [127:0] d);
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  initial begin
    m_tready = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && pending > 20) begin
        m_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_done = 1'b1;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    logic [15:0] v[8];
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    v = '{16'h0, 16'h0, 16'h10, 16'h0, 16'h0, 16'h10, 16'h4, 16'h4};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h10, 16'h0, 16'h0, 16'h10, 16'h0, 16'h0};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h10, 16'h0, 16'h0, 16'h10, 16'h10, 16'h0};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h10, 16'h0, 16'h0, 16'h10, 16'h0, 16'h10};
    send(pack8(v));
    v = '{16'h5, 16'h5, 16'h5, 16'h5, 16'h9, 16'h2, 16'h1, 16'h1};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h1, 16'h1, 16'h2, 16'h2, 16'h3, 16'h7};
    send(pack8(v));
    v = '{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff};
    send(pack8(v));
    v = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h1, 16'h8000, 16'h7fff};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h1, 16'h7fff, 16'h8000};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h1, 16'h8000, 16'h8000};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h3, 16'h0, 16'h0, 16'h3, 16'h1, 16'h0};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h0, 16'h3, 16'h3, 16'h0, 16'h2, 16'h0};
    send(pack8(v));
    v = '{16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h2, 16'h1, 16'h0};
    send(pack8(v));
    v = '{16'h0, 16'h0, 16'h0, 16'h2, 16'h2, 16'h0, 16'hffff, 16'h0};
    send(pack8(v));
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 150) calm = 1'b1;
      send(random_item());
      gap();
    end
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/bwt_pkg.sv
hdl/bwt_front.sv
hdl/bwt_div.sv
hdl/bwt_back.sv
hdl/barycentric_weights_2d.sv
bench/bwt_checker.sv
bench/tb_top.sv
